### hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared codes and types for the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Operation codes carried on in_func
  localparam logic [2:0] FN_REGISTER = 3'd0;
  localparam logic [2:0] FN_PAUSE    = 3'd1;
  localparam logic [2:0] FN_RESTART  = 3'd2;
  localparam logic [2:0] FN_DELAY    = 3'd3;
  localparam logic [2:0] FN_SET_OS   = 3'd4;
  localparam logic [2:0] FN_PROCESS  = 3'd5;

  // Outcome codes carried on out_outcome
  localparam logic [1:0] OC_OK     = 2'd0;
  localparam logic [1:0] OC_REJECT = 2'd1;
  localparam logic [1:0] OC_DUE    = 2'd2;
  localparam logic [1:0] OC_NONE   = 2'd3;

  // Most due tasks served by one process transaction
  localparam int unsigned  SERVED_W     = 5;
  localparam logic [4:0]   RESULT_LIMIT = 5'd16;

  // One-shot value meaning "none"
  localparam logic [32:0]  OS_NONE = 33'h1_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

### hdl/periodic_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_task_scheduler_top
// Task table with control ops and a sequential due-task scan.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low.
// Control transactions (register, pause, restart, delay-and-restart, set
// one-shot, and unknown codes) finish in the accepting cycle: their single
// result appears on the out_ ports for one cycle, flagged by out_valid, on
// the next cycle, and busy never rises for them. A process transaction
// raises busy and scans the registered slots in index order through one
// shared subtract-and-compare unit fed by a registered table read, one slot
// per cycle; busy stays high until every registered slot is judged and the
// flush state has reported, and falls sooner when the scan stops at the result
// limit. Each due task comes out as one result on its own cycle; the final
// result of a transaction carries out_last_of_run. The receiver cannot
// stall: every out_valid pulse is a result that is taken at once.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_top
  import pts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_task_index,
  input  logic [31:0] in_time_now,
  input  logic signed [32:0] in_interval_value,
  input  logic signed [32:0] in_one_shot_value,
  input  logic        in_start_running,
  output logic        out_valid,
  output logic [3:0]  out_served_task,
  output logic [1:0]  out_outcome,
  output logic        out_last_of_run
);

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  // Control state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_TASKS-1:0] run_r, run_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Scan bookkeeping
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]     ev_idx_r, ev_idx_nxt;
  logic [SERVED_W-1:0]  served_r, served_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic [31:0]          now_r, now_nxt;

  // Result payload
  logic [3:0]           out_task_r, out_task_nxt;
  logic [1:0]           out_outcome_r, out_outcome_nxt;
  logic                 out_last_r, out_last_nxt;

  // Task table: one write port, one registered read port per store
  logic [31:0]          base_mem [MAX_TASKS];
  logic [32:0]          os_mem   [MAX_TASKS];
  logic [31:0]          last_mem [MAX_TASKS];
  logic [31:0]          rd_base_r;
  logic [32:0]          rd_os_r;
  logic [31:0]          rd_last_r;

  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_base_en, wr_os_en, wr_last_en;
  logic [31:0]          wr_base_data;
  logic [32:0]          wr_os_data;
  logic [31:0]          wr_last_data;

  // Shared compare unit
  logic [31:0]          eff_interval;
  logic [31:0]          elapsed;
  logic                 due;

  logic                 accept;
  logic                 idx_ok;
  logic                 issue;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign idx_ok    = (32'(in_task_index) < 32'(count_r));
  assign issue     = (scan_idx_r < count_r);
  assign rd_addr   = scan_idx_r[IDX_W-1:0];

  // Effective interval: a non-negative one-shot wins over the base interval
  assign eff_interval = rd_os_r[32] ? rd_base_r : rd_os_r[31:0];
  assign elapsed      = now_r - rd_last_r;
  assign due          = ev_vld_r && run_r[ev_idx_r] && (elapsed >= eff_interval);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    run_nxt         = run_r;
    ev_vld_nxt      = 1'b0;
    ev_idx_nxt      = ev_idx_r;
    scan_idx_nxt    = scan_idx_r;
    served_nxt      = served_r;
    pend_vld_nxt    = pend_vld_r;
    pend_idx_nxt    = pend_idx_r;
    now_nxt         = now_r;
    out_valid_nxt   = 1'b0;
    out_task_nxt    = out_task_r;
    out_outcome_nxt = out_outcome_r;
    out_last_nxt    = out_last_r;
    wr_addr         = '0;
    wr_base_en      = 1'b0;
    wr_os_en        = 1'b0;
    wr_last_en      = 1'b0;
    wr_base_data    = in_interval_value[31:0];
    wr_os_data      = in_interval_value;
    wr_last_data    = in_time_now;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt   = 1'b1;
          out_last_nxt    = 1'b1;
          out_task_nxt    = in_task_index;
          out_outcome_nxt = OC_REJECT;
          wr_addr         = IDX_W'(in_task_index);
          case (in_func)
            FN_REGISTER: begin
              out_task_nxt = 4'd0;
              if (count_r != CNT_W'(MAX_TASKS)) begin
                wr_addr          = count_r[IDX_W-1:0];
                wr_base_en       = 1'b1;
                wr_os_en         = 1'b1;
                wr_last_en       = 1'b1;
                wr_os_data       = in_one_shot_value;
                run_nxt[count_r[IDX_W-1:0]] = in_start_running;
                count_nxt        = count_r + 1'b1;
                out_task_nxt     = 4'(count_r);
                out_outcome_nxt  = OC_OK;
              end
            end
            FN_PAUSE: begin
              if (idx_ok) begin
                run_nxt[IDX_W'(in_task_index)] = 1'b0;
                out_outcome_nxt = OC_OK;
              end
            end
            FN_RESTART: begin
              if (idx_ok) begin
                run_nxt[IDX_W'(in_task_index)] = 1'b1;
                out_outcome_nxt = OC_OK;
              end
            end
            FN_DELAY: begin
              if (idx_ok) begin
                wr_os_en   = 1'b1;
                wr_last_en = 1'b1;
                run_nxt[IDX_W'(in_task_index)] = 1'b1;
                out_outcome_nxt = OC_OK;
              end
            end
            FN_SET_OS: begin
              if (idx_ok) begin
                wr_os_en        = 1'b1;
                out_outcome_nxt = OC_OK;
              end
            end
            FN_PROCESS: begin
              // Hold the result back; the scan reports later
              out_valid_nxt = 1'b0;
              now_nxt       = in_time_now;
              scan_idx_nxt  = '0;
              served_nxt    = '0;
              pend_vld_nxt  = 1'b0;
              state_nxt     = ST_SCAN;
            end
            default: begin
              out_task_nxt = 4'd0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the read of the next slot while the current one is judged
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          ev_vld_nxt   = 1'b1;
          ev_idx_nxt   = rd_addr;
        end
        if (due) begin
          wr_addr      = ev_idx_r;
          wr_os_en     = 1'b1;
          wr_os_data   = OS_NONE;
          wr_last_en   = 1'b1;
          wr_last_data = now_r;
          // Release the previous due task; the newest one is held until the next due task or the flush
          if (pend_vld_r) begin
            out_valid_nxt   = 1'b1;
            out_task_nxt    = 4'(pend_idx_r);
            out_outcome_nxt = OC_DUE;
            out_last_nxt    = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = ev_idx_r;
          served_nxt   = served_r + 1'b1;
          if (served_r == RESULT_LIMIT - 1'b1) begin
            // Drop the read in flight and stop
            ev_vld_nxt = 1'b0;
            state_nxt  = ST_FLUSH;
          end
        end
        if (!issue && !ev_vld_r) begin
          state_nxt = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (pend_vld_r) begin
          out_task_nxt    = 4'(pend_idx_r);
          out_outcome_nxt = OC_DUE;
        end else begin
          out_task_nxt    = 4'd0;
          out_outcome_nxt = OC_NONE;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      run_r       <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      run_r       <= run_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_idx_r    <= scan_idx_nxt;
    ev_idx_r      <= ev_idx_nxt;
    served_r      <= served_nxt;
    pend_idx_r    <= pend_idx_nxt;
    now_r         <= now_nxt;
    out_task_r    <= out_task_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Table write port
  always_ff @(posedge clk) begin
    if (wr_base_en) begin
      base_mem[wr_addr] <= wr_base_data;
    end
    if (wr_os_en) begin
      os_mem[wr_addr] <= wr_os_data;
    end
    if (wr_last_en) begin
      last_mem[wr_addr] <= wr_last_data;
    end
  end

  // Table read port
  always_ff @(posedge clk) begin
    rd_base_r <= base_mem[rd_addr];
    rd_os_r   <= os_mem[rd_addr];
    rd_last_r <= last_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_served_task = out_task_r;
  assign out_outcome     = out_outcome_r;
  assign out_last_of_run = out_last_r;

endmodule
